// ----- rtl/sphere_contact_constraint_solver_core_macros.svh -----
// ----------------------------------------------------------------------------
// sphere contact solver assertion macros
// shared concurrent assertion forms, clocked on clk_i, off during reset
// ----------------------------------------------------------------------------
`ifndef SPHERE_CONTACT_CONSTRAINT_SOLVER_CORE_MACROS_SVH
`define SPHERE_CONTACT_CONSTRAINT_SOLVER_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
// combinational invariant under reset qualification
`define SCC_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("scc assertion failed");
// same-cycle implication
`define SCC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("scc implication failed");
`else
`define SCC_ASSERT(lbl, expr)
`define SCC_ASSERT_IMPL(lbl, ante, cons)
`endif
`endif

// ----- rtl/scc_pkg.sv -----
// ----------------------------------------------------------------------------
// scc_pkg
// shared widths and codes of the sphere contact solver
// ----------------------------------------------------------------------------
package scc_pkg;

  localparam int PosW  = 32;
  localparam int MagW  = 33;
  localparam int SqW   = 66;
  localparam int SideW = 8;
  localparam int DvdW  = 65;
  localparam int DvsW  = 33;
  localparam int QuoW  = 32;
  localparam int Lanes = 1;

  typedef enum logic [1:0] {
    StNoContact  = 2'd0,
    StSolved     = 2'd1,
    StImmovable  = 2'd2,
    StCoincident = 2'd3
  } status_e;

endpackage

// ----- rtl/sphere_contact_constraint_solver_core.sv -----
// ----------------------------------------------------------------------------
// sphere_contact_constraint_solver_core
// position correction of two touching spheres, fully pipelined
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid_i / in_ready_o) takes one particle pair per
//   transaction: two centres, two radii, two inverse masses, fixed point
//   output channel (out_valid_o / out_ready_i) gives one transaction per
//   pair: six saturated corrections and a contact status code
//   the path from input transaction to output valid runs through
//   3 setup stages, 33 root stages, 2 stages, 32 stages of the weight
//   divider, 1 product stage, 32 stages of the direction divider, 1 output
//   throughput is one pair per cycle while the receiver does not stall, set by
//   the bit per stage root and divider pipelines which all advance together
//   reset empties every stage, no transaction is in flight afterwards
//   when the receiver stalls with a result waiting, the whole pipeline
//   holds; in_ready_o follows the stall in the same cycle and nothing is
//   lost or repeated
//   statuses: no contact, solved, both immovable, coincident centres;
//   corrections are zero in all but the solved case
// ----------------------------------------------------------------------------
`include "sphere_contact_constraint_solver_core_macros.svh"

module sphere_contact_constraint_solver_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic signed [31:0]  pos0_x_i,
  input  logic signed [31:0]  pos0_y_i,
  input  logic signed [31:0]  pos0_z_i,
  input  logic signed [31:0]  pos1_x_i,
  input  logic signed [31:0]  pos1_y_i,
  input  logic signed [31:0]  pos1_z_i,
  input  logic [30:0]         radius0_i,
  input  logic [30:0]         radius1_i,
  input  logic [30:0]         weight0_i,
  input  logic [30:0]         weight1_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [31:0]  shift0_x_o,
  output logic signed [31:0]  shift0_y_o,
  output logic signed [31:0]  shift0_z_o,
  output logic signed [31:0]  shift1_x_o,
  output logic signed [31:0]  shift1_y_o,
  output logic signed [31:0]  shift1_z_o,
  output logic [1:0]          contact_status_o
);

  localparam int SQ_W = scc_pkg::SqW;
  localparam int MW = scc_pkg::MagW;
  localparam int DistW = SQ_W / 2;

  // side data through the root pipeline
  typedef struct packed {
    logic [2:0][MW-1:0] a;
    logic [2:0]         neg;
    logic [31:0]        rsum;
    logic [30:0]        w0;
    logic [30:0]        w1;
    logic [31:0]        wsum;
  } side_a_t;

  // side data through the weight divider
  typedef struct packed {
    logic [2:0][MW-1:0] a;
    logic [2:0]         neg;
    logic [DistW-1:0]   cdist;
    scc_pkg::status_e   status;
  } side_b_t;

  // side data through the direction divider
  typedef struct packed {
    logic [2:0]         neg;
    scc_pkg::status_e   status;
  } side_c_t;

  // global advance: every stage moves when the output slot is free or taken
  logic en;
  logic out_valid_q;
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  // stage 1: centre differences
  logic                     v1_q;
  logic signed [MW-1:0]     d1_q [3];
  logic [30:0]              r0_1_q, r1_1_q, w0_1_q, w1_1_q;
  // stage 2: magnitudes and squares
  logic                     v2_q;
  logic [2:0][MW-1:0]       a2_q;
  logic [2:0]               neg2_q;
  logic [SQ_W-1:0]          sq2_q [3];
  logic [30:0]              r0_2_q, r1_2_q, w0_2_q, w1_2_q;
  // stage 3: sum of squares, radius and weight sums
  logic                     v3_q;
  logic [SQ_W-1:0]          sq3_q;
  side_a_t                  sa3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d1_q[0] <= MW'(pos0_x_i) - MW'(pos1_x_i);
      d1_q[1] <= MW'(pos0_y_i) - MW'(pos1_y_i);
      d1_q[2] <= MW'(pos0_z_i) - MW'(pos1_z_i);
      r0_1_q  <= radius0_i;
      r1_1_q  <= radius1_i;
      w0_1_q  <= weight0_i;
      w1_1_q  <= weight1_i;
    end
  end

  logic [MW-1:0] a1 [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      a1[i] = d1_q[i][MW-1] ? MW'(-d1_q[i]) : MW'(d1_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        a2_q[i]   <= a1[i];
        neg2_q[i] <= d1_q[i][MW-1];
        sq2_q[i]  <= SQ_W'(a1[i]) * SQ_W'(a1[i]);
      end
      r0_2_q <= r0_1_q;
      r1_2_q <= r1_1_q;
      w0_2_q <= w0_1_q;
      w1_2_q <= w1_1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq3_q       <= sq2_q[0] + sq2_q[1] + sq2_q[2];
      sa3_q.a     <= a2_q;
      sa3_q.neg   <= neg2_q;
      sa3_q.rsum  <= 32'(r0_2_q) + 32'(r1_2_q);
      sa3_q.w0    <= w0_2_q;
      sa3_q.w1    <= w1_2_q;
      sa3_q.wsum  <= 32'(w0_2_q) + 32'(w1_2_q);
    end
  end

  // centre distance
  logic             sq_valid;
  logic [DistW-1:0] cdist;
  side_a_t          sa_r;

  scc_sqrt #(
    .IN_W   (SQ_W),
    .SIDE_W ($bits(side_a_t))
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v3_q),
    .op_i    (sq3_q),
    .side_i  (sa3_q),
    .valid_o (sq_valid),
    .root_o  (cdist),
    .side_o  (sa_r)
  );

  // stage 4: classify and penetration depth
  logic             v4_q;
  logic [31:0]      pen4_q;
  logic [30:0]      w0_4_q, w1_4_q;
  logic [31:0]      wsum4_q;
  side_b_t          sb4_q;
  scc_pkg::status_e status4;

  always_comb begin
    if (sa_r.wsum == '0) begin
      status4 = scc_pkg::StImmovable;
    end else if (cdist >= DistW'(sa_r.rsum)) begin
      status4 = scc_pkg::StNoContact;
    end else if (cdist == '0) begin
      status4 = scc_pkg::StCoincident;
    end else begin
      status4 = scc_pkg::StSolved;
    end
  end

  // stage 5: weighted penetration products
  logic             v5_q;
  logic [1:0][62:0] pw5_q;
  logic [31:0]      wsum5_q;
  side_b_t          sb5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en) begin
      v4_q <= sq_valid;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pen4_q       <= sa_r.rsum - cdist[31:0];
      w0_4_q       <= sa_r.w0;
      w1_4_q       <= sa_r.w1;
      wsum4_q      <= sa_r.wsum;
      sb4_q.a      <= sa_r.a;
      sb4_q.neg    <= sa_r.neg;
      sb4_q.cdist  <= cdist;
      sb4_q.status <= status4;

      pw5_q[0] <= 63'(pen4_q) * 63'(w0_4_q);
      pw5_q[1] <= 63'(pen4_q) * 63'(w1_4_q);
      wsum5_q  <= wsum4_q;
      sb5_q    <= sb4_q;
    end
  end

  // lambda times weight for each particle
  logic             k_valid;
  logic [1:0][31:0] k;
  side_b_t          sb_r;

  scc_div #(
    .LANES  (2),
    .DW     (63),
    .VW     (32),
    .QW     (32),
    .SIDE_W ($bits(side_b_t))
  ) u_div_weight (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v5_q),
    .dvd_i   (pw5_q),
    .dvs_i   (wsum5_q),
    .side_i  (sb5_q),
    .valid_o (k_valid),
    .quo_o   (k),
    .side_o  (sb_r)
  );

  // stage 6: scale each axis magnitude, lanes 0..2 first particle
  logic                    v6_q;
  logic [5:0][DistW+31:0]  ka6_q;
  logic [DistW-1:0]        dist6_q;
  side_c_t                 sc6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
    end else if (en) begin
      v6_q <= k_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ka6_q[i]   <= (DistW+32)'(k[0]) * (DistW+32)'(sb_r.a[i]);
        ka6_q[i+3] <= (DistW+32)'(k[1]) * (DistW+32)'(sb_r.a[i]);
      end
      dist6_q       <= sb_r.cdist;
      sc6_q.neg     <= sb_r.neg;
      sc6_q.status  <= sb_r.status;
    end
  end

  // divide by distance for the unit direction
  logic             m_valid;
  logic [5:0][31:0] m;
  side_c_t          sc_r;

  scc_div #(
    .LANES  (6),
    .DW     (DistW + 32),
    .VW     (DistW),
    .QW     (32),
    .SIDE_W ($bits(side_c_t))
  ) u_div_dir (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v6_q),
    .dvd_i   (ka6_q),
    .dvs_i   (dist6_q),
    .side_i  (sc6_q),
    .valid_o (m_valid),
    .quo_o   (m),
    .side_o  (sc_r)
  );

  // output register: sign, saturation, zero outside the solved case
  logic [5:0][31:0] shift_d, shift_q;
  logic [1:0]       status_q;
  logic             neg_l;

  always_comb begin
    neg_l = 1'b0;
    for (int l = 0; l < 6; l++) begin
      neg_l = (l < 3) ? sc_r.neg[l % 3] : !sc_r.neg[l % 3];
      if (sc_r.status != scc_pkg::StSolved) begin
        shift_d[l] = '0;
      end else if (neg_l) begin
        shift_d[l] = (m[l] > 32'h8000_0000) ? 32'h8000_0000 : 32'(-m[l]);
      end else begin
        shift_d[l] = (m[l] > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : m[l];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= m_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      shift_q  <= shift_d;
      status_q <= sc_r.status;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign shift0_x_o       = shift_q[0];
  assign shift0_y_o       = shift_q[1];
  assign shift0_z_o       = shift_q[2];
  assign shift1_x_o       = shift_q[3];
  assign shift1_y_o       = shift_q[4];
  assign shift1_z_o       = shift_q[5];
  assign contact_status_o = status_q;

  // corrections only exist for a solved contact
  `SCC_ASSERT_IMPL(a_zero_unsolved, out_valid_o && (contact_status_o != scc_pkg::StSolved), shift_q == '0)
  // the two particles move apart along the x axis
  `SCC_ASSERT_IMPL(a_opposite_x, out_valid_o && (shift0_x_o != '0) && (shift1_x_o != '0), shift0_x_o[31] != shift1_x_o[31])
  // a stalled output holds the pipeline entry closed
  `SCC_ASSERT(a_stall_blocks, (out_valid_o && !out_ready_i) == !in_ready_o)

endmodule

// ----- rtl/scc_sqrt.sv -----
// ----------------------------------------------------------------------------
// scc_sqrt
// pipelined floor square root, one result bit per stage, side data carried
// ----------------------------------------------------------------------------
module scc_sqrt #(
  parameter int IN_W   = scc_pkg::SqW,
  parameter int SIDE_W = scc_pkg::SideW
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic [IN_W-1:0]       op_i,
  input  logic [SIDE_W-1:0]     side_i,
  output logic                  valid_o,
  output logic [IN_W/2-1:0]     root_o,
  output logic [SIDE_W-1:0]     side_o
);

  localparam int N  = IN_W / 2;
  localparam int RW = N + 3;

  logic              vld_q  [1:N];
  logic [IN_W-1:0]   op_q   [1:N];
  logic [RW-1:0]     rem_q  [1:N];
  logic [N-1:0]      root_q [1:N];
  logic [SIDE_W-1:0] side_q [1:N];

  logic              vld_w  [0:N];
  logic [IN_W-1:0]   op_w   [0:N];
  logic [RW-1:0]     rem_w  [0:N];
  logic [N-1:0]      root_w [0:N];
  logic [SIDE_W-1:0] side_w [0:N];

  assign vld_w[0]  = valid_i;
  assign op_w[0]   = op_i;
  assign rem_w[0]  = '0;
  assign root_w[0] = '0;
  assign side_w[0] = side_i;

  for (genvar s = 0; s < N; s++) begin : g_stage
    localparam int P = N - 1 - s;
    logic [RW-1:0] rem_sh, trial, rem_d;
    logic [N-1:0]  root_d;
    logic          ge;

    assign vld_w[s+1]  = vld_q[s+1];
    assign op_w[s+1]   = op_q[s+1];
    assign rem_w[s+1]  = rem_q[s+1];
    assign root_w[s+1] = root_q[s+1];
    assign side_w[s+1] = side_q[s+1];

    always_comb begin
      rem_sh = {rem_w[s][RW-3:0], op_w[s][2*P+1:2*P]};
      trial  = RW'({root_w[s], 2'b01});
      ge     = (rem_sh >= trial);
      rem_d  = ge ? (rem_sh - trial) : rem_sh;
      root_d = {root_w[s][N-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[s+1] <= vld_w[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        op_q[s+1]   <= op_w[s];
        rem_q[s+1]  <= rem_d;
        root_q[s+1] <= root_d;
        side_q[s+1] <= side_w[s];
      end
    end
  end

  assign valid_o = vld_w[N];
  assign root_o  = root_w[N];
  assign side_o  = side_w[N];

endmodule

// ----- rtl/scc_div.sv -----
// ----------------------------------------------------------------------------
// scc_div
// pipelined restoring divider, several lanes over one divisor, bit per stage
// ----------------------------------------------------------------------------
module scc_div #(
  parameter int LANES  = scc_pkg::Lanes,
  parameter int DW     = scc_pkg::DvdW,
  parameter int VW     = scc_pkg::DvsW,
  parameter int QW     = scc_pkg::QuoW,
  parameter int SIDE_W = scc_pkg::SideW
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [LANES-1:0][DW-1:0]   dvd_i,
  input  logic [VW-1:0]              dvs_i,
  input  logic [SIDE_W-1:0]          side_i,
  output logic                       valid_o,
  output logic [LANES-1:0][QW-1:0]   quo_o,
  output logic [SIDE_W-1:0]          side_o
);

  // quotient is assumed to fit in QW bits
  localparam int RW = (DW > VW + QW) ? DW : VW + QW;

  logic                       vld_q  [1:QW];
  logic [VW-1:0]              dvs_q  [1:QW];
  logic [LANES-1:0][RW-1:0]   rem_q  [1:QW];
  logic [LANES-1:0][QW-1:0]   quo_q  [1:QW];
  logic [SIDE_W-1:0]          side_q [1:QW];

  logic                       vld_w  [0:QW];
  logic [VW-1:0]              dvs_w  [0:QW];
  logic [LANES-1:0][RW-1:0]   rem_w  [0:QW];
  logic [LANES-1:0][QW-1:0]   quo_w  [0:QW];
  logic [SIDE_W-1:0]          side_w [0:QW];

  assign vld_w[0]  = valid_i;
  assign dvs_w[0]  = dvs_i;
  assign quo_w[0]  = '0;
  assign side_w[0] = side_i;
  for (genvar l = 0; l < LANES; l++) begin : g_in
    assign rem_w[0][l] = RW'(dvd_i[l]);
  end

  for (genvar s = 0; s < QW; s++) begin : g_stage
    localparam int B = QW - 1 - s;
    logic [RW-1:0]            trial;
    logic [LANES-1:0][RW-1:0] rem_d;
    logic [LANES-1:0][QW-1:0] quo_d;

    assign vld_w[s+1]  = vld_q[s+1];
    assign dvs_w[s+1]  = dvs_q[s+1];
    assign rem_w[s+1]  = rem_q[s+1];
    assign quo_w[s+1]  = quo_q[s+1];
    assign side_w[s+1] = side_q[s+1];

    always_comb begin
      trial = RW'(dvs_w[s]) << B;
      for (int l = 0; l < LANES; l++) begin
        if (rem_w[s][l] >= trial) begin
          rem_d[l] = rem_w[s][l] - trial;
          quo_d[l] = quo_w[s][l] | (QW'(1) << B);
        end else begin
          rem_d[l] = rem_w[s][l];
          quo_d[l] = quo_w[s][l];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[s+1] <= vld_w[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dvs_q[s+1]  <= dvs_w[s];
        rem_q[s+1]  <= rem_d;
        quo_q[s+1]  <= quo_d;
        side_q[s+1] <= side_w[s];
      end
    end
  end

  assign valid_o = vld_w[QW];
  assign quo_o   = quo_w[QW];
  assign side_o  = side_w[QW];

endmodule
